// File: hdl/siren_sweep_sequencer_assert.svh
// Assertion macros for the sequencer's RTL.
`ifndef SIREN_SWEEP_SEQUENCER_ASSERT_SVH
`define SIREN_SWEEP_SEQUENCER_ASSERT_SVH

// Checked on every rising edge of clk while reset is released.
`define SSQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SSQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ssq_pkg.sv
`default_nettype none
package ssq_pkg;

	localparam int FREQ_W  = 10;
	localparam int HOLD_W  = 8;
	localparam int PAUSE_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [FREQ_W-1:0]  LOW_FREQ_RST    = 10'd200;
	localparam logic [FREQ_W-1:0]  HIGH_FREQ_RST   = 10'd800;
	localparam logic [HOLD_W-1:0]  HOLD_UP_RST     = 8'd5;
	localparam logic [HOLD_W-1:0]  HOLD_DOWN_RST   = 8'd10;
	localparam logic [PAUSE_W-1:0] PAUSE_TICKS_RST = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_FREQ    = 3'd0,
		CFG_HIGH_FREQ   = 3'd1,
		CFG_HOLD_UP     = 3'd2,
		CFG_HOLD_DOWN   = 3'd3,
		CFG_PAUSE_TICKS = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		OP_TICK     = 1'b0,
		OP_SET_PLAY = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		PH_RISE    = 4'b0001,
		PH_PAUSE   = 4'b0010,
		PH_FALL    = 4'b0100,
		PH_RESTART = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  low_freq;
		logic [FREQ_W-1:0]  high_freq;
		logic [HOLD_W-1:0]  hold_up;
		logic [HOLD_W-1:0]  hold_down;
		logic [PAUSE_W-1:0] pause_ticks;
	} cfg_t;

	typedef struct packed {
		logic opcode;
		logic play;
	} cmd_t;

	typedef struct packed {
		logic              tone_start;
		logic [FREQ_W-1:0] tone_freq;
		logic              silence;
		logic              playing;
	} rsp_t;

endpackage
`default_nettype wire

// File: hdl/ssq_stream_if.sv
`default_nettype none
interface ssq_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/ssq_cfg.sv
`default_nettype none
module ssq_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                we,
	input  wire logic [ssq_pkg::CFG_IDX_W-1:0]       index,
	input  wire logic [ssq_pkg::CFG_DATA_W-1:0]      data,
	output ssq_pkg::cfg_t                            cfg
);

	ssq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_freq    <= ssq_pkg::LOW_FREQ_RST;
			cfg_q.high_freq   <= ssq_pkg::HIGH_FREQ_RST;
			cfg_q.hold_up     <= ssq_pkg::HOLD_UP_RST;
			cfg_q.hold_down   <= ssq_pkg::HOLD_DOWN_RST;
			cfg_q.pause_ticks <= ssq_pkg::PAUSE_TICKS_RST;
		end else if (we) begin
			unique case (ssq_pkg::cfg_idx_t'(index))
				ssq_pkg::CFG_LOW_FREQ:    cfg_q.low_freq    <= data[ssq_pkg::FREQ_W-1:0];
				ssq_pkg::CFG_HIGH_FREQ:   cfg_q.high_freq   <= data[ssq_pkg::FREQ_W-1:0];
				ssq_pkg::CFG_HOLD_UP:     cfg_q.hold_up     <= data[ssq_pkg::HOLD_W-1:0];
				ssq_pkg::CFG_HOLD_DOWN:   cfg_q.hold_down   <= data[ssq_pkg::HOLD_W-1:0];
				ssq_pkg::CFG_PAUSE_TICKS: cfg_q.pause_ticks <= data[ssq_pkg::PAUSE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: hdl/ssq_core.sv
`default_nettype none
module ssq_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ssq_pkg::cfg_t cfg,
	input  wire logic          step,
	input  wire ssq_pkg::cmd_t cmd,
	output ssq_pkg::rsp_t      rsp
);

	// Pause compare width: wide enough for both the counter and the register.
	localparam int CMP_W = (COUNT_WIDTH > ssq_pkg::PAUSE_W) ? COUNT_WIDTH : ssq_pkg::PAUSE_W;

	ssq_pkg::phase_t                  phase_q, phase_d;
	logic [ssq_pkg::FREQ_W-1:0]       freq_q, freq_d;
	logic [COUNT_WIDTH-1:0]           cnt_q, cnt_d;
	logic                             act_q, act_d;
	logic                             play_q, play_d;

	logic [COUNT_WIDTH-1:0]           cnt_inc;
	logic [ssq_pkg::HOLD_W-1:0]       hold_sel;
	logic                             hold_done;
	logic                             pause_done;
	logic [ssq_pkg::FREQ_W-1:0]       freq_next_tone;
	logic                             tone_start;
	logic [ssq_pkg::FREQ_W-1:0]       tone_freq;
	logic                             silence;

	assign cnt_inc    = cnt_q + COUNT_WIDTH'(1);
	assign hold_sel   = (phase_q == ssq_pkg::PH_FALL) ? cfg.hold_down : cfg.hold_up;
	assign hold_done  = cnt_inc >= COUNT_WIDTH'(hold_sel);
	assign pause_done = CMP_W'(cnt_inc) >= CMP_W'(cfg.pause_ticks);
	assign freq_next_tone = (phase_q == ssq_pkg::PH_FALL) ?
		freq_q - ssq_pkg::FREQ_W'(1) : freq_q + ssq_pkg::FREQ_W'(1);

	always_comb begin
		phase_d    = phase_q;
		freq_d     = freq_q;
		cnt_d      = cnt_q;
		act_d      = act_q;
		play_d     = play_q;
		tone_start = 1'b0;
		tone_freq  = '0;
		silence    = 1'b0;

		if (cmd.opcode == ssq_pkg::OP_SET_PLAY) begin
			play_d  = cmd.play;
			freq_d  = cfg.low_freq;
			phase_d = ssq_pkg::PH_RISE;
		end else if (!play_q) begin
			silence = 1'b1;
		end else begin
			unique case (phase_q)
				ssq_pkg::PH_RISE, ssq_pkg::PH_FALL: begin
					if ((phase_q == ssq_pkg::PH_RISE) ? (freq_q < cfg.high_freq)
							: (freq_q > cfg.low_freq)) begin
						// A tone is started on its first tick, then held.
						if (!act_q) begin
							tone_start = 1'b1;
							tone_freq  = freq_q;
							cnt_d      = '0;
							act_d      = 1'b1;
						end else begin
							cnt_d = cnt_inc;
							if (hold_done) begin
								freq_d = freq_next_tone;
								act_d  = 1'b0;
							end
						end
					end else if (phase_q == ssq_pkg::PH_RISE) begin
						phase_d = ssq_pkg::PH_PAUSE;
						freq_d  = '0;
					end else begin
						phase_d = ssq_pkg::PH_RESTART;
					end
				end
				ssq_pkg::PH_PAUSE: begin
					cnt_d = cnt_inc;
					if (pause_done) begin
						freq_d  = cfg.high_freq;
						act_d   = 1'b0;
						phase_d = ssq_pkg::PH_FALL;
					end
				end
				default: begin
					phase_d = ssq_pkg::PH_RISE;
					freq_d  = cfg.low_freq;
					act_d   = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssq_pkg::PH_RISE;
			freq_q  <= ssq_pkg::LOW_FREQ_RST;
			cnt_q   <= '0;
			act_q   <= 1'b0;
			play_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			freq_q  <= freq_d;
			cnt_q   <= cnt_d;
			act_q   <= act_d;
			play_q  <= play_d;
		end
	end

	assign rsp.tone_start = tone_start;
	assign rsp.tone_freq  = tone_freq;
	assign rsp.silence    = silence;
	assign rsp.playing    = play_d;

endmodule
`default_nettype wire

// File: hdl/siren_sweep_sequencer.sv
// Channel  Direction  Payload                                      Accepted when
// cmd      in         opcode, play                                 cmd.valid && cmd.ready
// rsp      out        tone_start, tone_freq, silence, playing      rsp.valid && rsp.ready
// cfg      in         cfg_we, cfg_index, cfg_data                  cfg_we high at the edge
//
// Every item gives one result: it passes through the input register and then the
// result register. The input register and the result register each hold one
// item, so an item can be accepted in every cycle while the result is not stalled.
// The sequencer state advances once per item, as it moves to the result register.
// arst_n clears the state, the valid flags and loads the register reset values.
// A stalled result holds the result register, which then holds the input register.
`default_nettype none
`include "siren_sweep_sequencer_assert.svh"
module siren_sweep_sequencer #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ssq_stream_if.sink                           cmd,
	ssq_stream_if.source                         rsp,
	input  wire logic                            cfg_we,
	input  wire logic [ssq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ssq_pkg::CFG_DATA_W-1:0]  cfg_data
);

	ssq_pkg::cfg_t cfg;
	ssq_pkg::cmd_t cmd_s1;
	ssq_pkg::rsp_t rsp_d;
	ssq_pkg::rsp_t rsp_q;
	logic          valid_s1;
	logic          rsp_valid_q;
	logic          advance;

	ssq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// The item in the input register is processed when the result register is
	// free or is being emptied in the same cycle.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Payload registers carry no reset; the valid flags guard them.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.payload;
		end
	end

	ssq_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.cmd    (cmd_s1),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// A processed item always lands in the result register.
	`SSQ_ASSERT(a_advance_fills, advance |=> rsp_valid_q, "processed item did not reach result")
	// Silence and a tone start never come from the same tick.
	`SSQ_ASSERT(a_tone_xor_silence, rsp_valid_q |-> !(rsp_q.silence && rsp_q.tone_start), "tone during silence")
	// Silence is only reported while the play enable is off.
	`SSQ_ASSERT(a_silence_not_playing, rsp_valid_q && rsp_q.silence |-> !rsp_q.playing, "silence while playing")
	// The frequency field is zero unless a tone starts.
	`SSQ_ASSERT(a_freq_zero, rsp_valid_q && !rsp_q.tone_start |-> rsp_q.tone_freq == '0, "stray tone frequency")
	// No item is ever offered while reset is asserted.
	`SSQ_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !rsp_valid_q && !valid_s1, "valid during reset")

endmodule
`default_nettype wire
